// ----- sv/tiq_pkg.sv -----
// ----------------------------------------------------------------------------
// tiq_pkg: shared types for the time ordered insert queue
// controller states, status codes and the control/status bundles
// ----------------------------------------------------------------------------
package tiq_pkg;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_HOLD = 1'b1
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic    load;
		logic    do_insert;
		logic    do_pop;
		status_t code;
	} cmd_t;

	// occupancy flags from datapath to controller
	typedef struct packed {
		logic empty;
		logic full;
	} flags_t;

endpackage

// ----- sv/tiq_ctrl.sv -----
// ----------------------------------------------------------------------------
// tiq_ctrl: handshake controller
// tracks the result register and decides the outcome of each item
// ----------------------------------------------------------------------------
module tiq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic            action,
	output logic            m_tvalid,
	input  logic            m_tready,
	input  tiq_pkg::flags_t flags,
	output tiq_pkg::cmd_t   cmd
);

	tiq_pkg::state_t state_q, state_d;
	logic accept;

	assign s_tready = (state_q == tiq_pkg::ST_IDLE) || m_tready;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tiq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			tiq_pkg::ST_IDLE: begin
				if (accept) state_d = tiq_pkg::ST_HOLD;
			end
			tiq_pkg::ST_HOLD: begin
				if (accept) state_d = tiq_pkg::ST_HOLD;
				else if (m_tready) state_d = tiq_pkg::ST_IDLE;
			end
			default: state_d = tiq_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		m_tvalid      = (state_q == tiq_pkg::ST_HOLD);
		cmd.load      = accept;
		cmd.do_insert = 1'b0;
		cmd.do_pop    = 1'b0;
		cmd.code      = tiq_pkg::STATUS_OK;
		if (action) begin
			if (flags.empty) cmd.code = tiq_pkg::STATUS_EMPTY;
			else cmd.do_pop = accept;
		end else begin
			if (flags.full) cmd.code = tiq_pkg::STATUS_FULL;
			else cmd.do_insert = accept;
		end
	end

endmodule

// ----- sv/tiq_datapath.sv -----
// ----------------------------------------------------------------------------
// tiq_datapath: sorted cell array and result register
// every cell compares its key with the new key in parallel
// ----------------------------------------------------------------------------
module tiq_datapath #(
	parameter int DEPTH     = 16,
	parameter int KEY_WIDTH = 16,
	parameter int TAG_WIDTH = 8,
	parameter int CW        = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tiq_pkg::cmd_t        cmd,
	input  logic [KEY_WIDTH-1:0] in_key,
	input  logic [TAG_WIDTH-1:0] in_tag,
	output tiq_pkg::flags_t      flags,
	output logic                 res_valid,
	output logic [KEY_WIDTH-1:0] res_key,
	output logic [TAG_WIDTH-1:0] res_tag,
	output tiq_pkg::status_t     res_status,
	output logic [CW-1:0]        res_count
);

	logic [KEY_WIDTH-1:0] key_q [DEPTH];
	logic [TAG_WIDTH-1:0] tag_q [DEPTH];
	logic [KEY_WIDTH-1:0] key_d [DEPTH];
	logic [TAG_WIDTH-1:0] tag_d [DEPTH];
	logic [DEPTH-1:0]     lt;
	logic [CW-1:0]        count_q;

	assign flags.empty = (count_q == '0);
	assign flags.full  = (count_q == CW'(DEPTH));

	// cells below the count with a smaller key stay put; sorted order keeps lt a prefix
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			lt[i] = (CW'(i) < count_q) && (key_q[i] < in_key);
		end
	end

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			key_d[i] = key_q[i];
			tag_d[i] = tag_q[i];
			if (cmd.do_pop) begin
				if (i < DEPTH - 1) begin
					key_d[i] = key_q[i+1];
					tag_d[i] = tag_q[i+1];
				end
			end else if (cmd.do_insert && !lt[i]) begin
				if (i == 0) begin
					key_d[i] = in_key;
					tag_d[i] = in_tag;
				end else if (lt[i-1]) begin
					key_d[i] = in_key;
					tag_d[i] = in_tag;
				end else begin
					key_d[i] = key_q[i-1];
					tag_d[i] = tag_q[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			key_q[i] <= key_d[i];
			tag_q[i] <= tag_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.do_pop) begin
			count_q <= count_q - CW'(1);
		end else if (cmd.do_insert) begin
			count_q <= count_q + CW'(1);
		end
	end

	// result register, payload only
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_valid  <= cmd.do_pop;
			res_key    <= cmd.do_pop ? key_q[0] : '0;
			res_tag    <= cmd.do_pop ? tag_q[0] : '0;
			res_status <= cmd.code;
			if (cmd.do_pop) res_count <= count_q - CW'(1);
			else if (cmd.do_insert) res_count <= count_q + CW'(1);
			else res_count <= count_q;
		end
	end

endmodule

// ----- sv/time_ordered_insert_queue.sv -----
// ----------------------------------------------------------------------------
// time_ordered_insert_queue: sorted key/tag queue with insert and pop
// the result is registered and valid on the master side in the cycle after item accept
// throughput: one item per cycle while the master side takes each result;
// the slave side stays ready while the held result is being taken
// reset: entry count cleared at once; cell contents undefined until written
// ----------------------------------------------------------------------------
module time_ordered_insert_queue #(
	parameter int DEPTH     = 16,
	parameter int KEY_WIDTH = 16,
	parameter int TAG_WIDTH = 8
) (
	input  logic clk,
	input  logic arst_n,
	// slave side
	input  logic s_tvalid,
	output logic s_tready,
	// fields from bit 0: key, tag, zero fill
	input  logic [((KEY_WIDTH+TAG_WIDTH+7)/8)*8-1:0] s_tdata,
	// fields from bit 0: action
	input  logic s_tuser,
	// master side
	output logic m_tvalid,
	input  logic m_tready,
	// fields from bit 0: out_key, out_tag, entry_count, zero fill
	output logic [((KEY_WIDTH+TAG_WIDTH+$clog2(DEPTH+1)+7)/8)*8-1:0] m_tdata,
	// fields from bit 0: out_valid, status
	output logic [2:0] m_tuser
);

	// entry count must hold DEPTH itself
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int OUT_W = ((KEY_WIDTH + TAG_WIDTH + CW + 7) / 8) * 8;

	tiq_pkg::cmd_t    cmd;
	tiq_pkg::flags_t  flags;
	logic                 res_valid;
	logic [KEY_WIDTH-1:0] res_key;
	logic [TAG_WIDTH-1:0] res_tag;
	tiq_pkg::status_t     res_status;
	logic [CW-1:0]        res_count;

	// controller: result register occupancy and outcome of each item
	tiq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.action   (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.flags    (flags),
		.cmd      (cmd)
	);

	// datapath: sorted cells, count and result payload
	tiq_datapath #(
		.DEPTH     (DEPTH),
		.KEY_WIDTH (KEY_WIDTH),
		.TAG_WIDTH (TAG_WIDTH),
		.CW        (CW)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.in_key     (s_tdata[KEY_WIDTH-1:0]),
		.in_tag     (s_tdata[KEY_WIDTH +: TAG_WIDTH]),
		.flags      (flags),
		.res_valid  (res_valid),
		.res_key    (res_key),
		.res_tag    (res_tag),
		.res_status (res_status),
		.res_count  (res_count)
	);

	// pack the result, zero fill above the count
	assign m_tdata = OUT_W'({res_count, res_tag, res_key});
	assign m_tuser = {res_status, res_valid};

endmodule
